// ===== rtl/core/psb_pkg.sv =====
`default_nettype none

package psb_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESOLVE
    } state_t;

    // one stored slot
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  prio;
        logic [1:0]  src;
    } entry_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic step;
        logic remove;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/psb_if.sv =====
`default_nettype none

// command request channel
interface psb_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] value;
    logic [2:0]         priority_req;
    logic [1:0]         source;

    modport source_mp (output valid, output cmd, output value, output priority_req,
                       output source, input ready);
    modport sink (input valid, input cmd, input value, input priority_req,
                  input source, output ready);
endinterface

// result channel
interface psb_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [2:0]         out_priority;
    logic [1:0]         out_source;
    logic [4:0]         occupancy;
    logic signed [31:0] total_sum;
    logic signed [31:0] source_sum;

    modport source (output valid, output status, output out_value, output out_priority,
                    output out_source, output occupancy, output total_sum,
                    output source_sum, input ready);
    modport sink (input valid, input status, input out_value, input out_priority,
                  input out_source, input occupancy, input total_sum,
                  input source_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/psb_slot_mem.sv =====
`default_nettype none

module psb_slot_mem #(
    parameter int SLOTS = 16,
    localparam int AW = $clog2(SLOTS)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire psb_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output psb_pkg::entry_t      rd_data
);

    psb_pkg::entry_t mem_reg [SLOTS];
    psb_pkg::entry_t rd_data_reg;

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psb_scan.sv =====
`default_nettype none

module psb_scan #(
    parameter int SLOTS = 16,
    localparam int AW = $clog2(SLOTS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psb_pkg::scan_ctl_t ctl,
    input  wire logic               slot_vld,
    input  wire psb_pkg::entry_t    slot,
    input  wire logic [AW-1:0]      slot_idx,
    output logic                    found,
    output logic [AW-1:0]           best_idx,
    output psb_pkg::entry_t         best
);

    logic            found_reg;
    logic [AW-1:0]   best_idx_reg;
    psb_pkg::entry_t best_reg;
    logic            take;

    // shared compare: lowest free slot on insert, smallest priority on remove;
    // strict less-than keeps the lowest index on a tie
    always_comb
    begin
        if (ctl.remove)
        begin
            take = ctl.step && slot_vld && (!found_reg || (slot.prio < best_reg.prio));
        end
        else
        begin
            take = ctl.step && !slot_vld && !found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    // candidate payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= slot_idx;
            best_reg     <= slot;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule

`default_nettype wire

// ===== rtl/core/priority_slot_buffer_top.sv =====
// A request is taken only in idle, so a new one waits until the last has resolved.
// The scan visits one slot per cycle through the slot memory's single read port;
// a drain state then empties the read register, and a resolve state, which waits
// while the result register is still held, updates state and loads the result.
// Reset (rst_n, asynchronous): valid bits, count, sums and control cleared;
// slot contents are not cleared and need no clearing pass.
`default_nettype none

module priority_slot_buffer_top #(
    parameter int SLOTS   = 16,
    parameter int SOURCES = 3
) (
    input  wire logic clk,
    input  wire logic rst_n,
    psb_req_if.sink   request,
    psb_res_if.source result
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    // sequencer
    psb_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    psb_pkg::scan_ctl_t ctl;
    logic               rd_en;
    logic               resolve;

    // captured request
    logic        cmd_reg;
    logic [31:0] val_reg;
    logic [2:0]  pri_reg;
    logic [1:0]  src_reg;

    // read pipeline alignment
    logic          step_d_reg;
    logic          vld_d_reg;
    logic [AW-1:0] idx_d_reg;

    // block state
    logic [SLOTS-1:0] slot_valid_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      total_reg;
    logic [31:0]      per_src_reg [SOURCES];

    // result register
    logic        res_valid_reg;
    logic [1:0]  res_status_reg;
    logic [31:0] res_value_reg;
    logic [2:0]  res_prio_reg;
    logic [1:0]  res_src_reg;
    logic [4:0]  res_occ_reg;
    logic [31:0] res_total_reg;
    logic [31:0] res_ssum_reg;

    // scan unit and memory
    psb_pkg::entry_t rd_data;
    psb_pkg::entry_t best;
    psb_pkg::entry_t wr_data;
    logic            found;
    logic [AW-1:0]   best_idx;
    logic            mem_wr_en;

    logic          req_fire;
    logic          res_free;
    logic          is_remove;
    logic          ins_ok;
    logic          rem_ok;
    logic          src_ok;
    logic [SW-1:0] sidx;
    logic [31:0]   add_total;
    logic [31:0]   add_src;

    assign req_fire      = request.valid && request.ready;
    assign request.ready = (state_reg == psb_pkg::ST_IDLE);
    assign res_free      = !res_valid_reg || result.ready;

    // next state and sequencer outputs
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl.clear  = 1'b0;
        ctl.step   = step_d_reg;
        ctl.remove = (cmd_reg == psb_pkg::CMD_REMOVE);
        rd_en      = 1'b0;
        resolve    = 1'b0;
        unique case (state_reg)
            psb_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    ctl.clear  = 1'b1;
                    cnt_next   = '0;
                    state_next = psb_pkg::ST_SCAN;
                end
            end
            psb_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
                if (cnt_reg == AW'(SLOTS - 1))
                begin
                    state_next = psb_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            psb_pkg::ST_DRAIN:
            begin
                state_next = psb_pkg::ST_RESOLVE;
            end
            psb_pkg::ST_RESOLVE:
            begin
                if (res_free)
                begin
                    resolve    = 1'b1;
                    state_next = psb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= psb_pkg::ST_IDLE;
            cnt_reg    <= '0;
            step_d_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            step_d_reg <= (state_reg == psb_pkg::ST_SCAN);
        end
    end

    // request capture and valid-bit alignment with the memory read
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= request.cmd;
            val_reg <= request.value;
            pri_reg <= request.priority_req;
            src_reg <= request.source;
        end
        vld_d_reg <= slot_valid_reg[cnt_reg];
        idx_d_reg <= cnt_reg;
    end

    psb_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (best_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    psb_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .slot_vld (vld_d_reg),
        .slot     (rd_data),
        .slot_idx (idx_d_reg),
        .found    (found),
        .best_idx (best_idx),
        .best     (best)
    );

    // outcome of the scan
    assign is_remove  = (cmd_reg == psb_pkg::CMD_REMOVE);
    assign ins_ok     = !is_remove && found;
    assign rem_ok     = is_remove && found;
    assign src_ok     = (int'(best.src) < SOURCES);
    assign sidx       = SW'(best.src);
    assign add_total  = total_reg + best.value;
    assign add_src    = per_src_reg[sidx] + best.value;
    assign mem_wr_en  = resolve && ins_ok;
    assign wr_data    = '{value: val_reg, prio: pri_reg, src: src_reg};

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rem_ok && (count_reg != '0))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // state update on resolve
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            for (int s = 0; s < SOURCES; s++)
            begin
                per_src_reg[s] <= '0;
            end
        end
        else if (resolve)
        begin
            count_reg <= count_next;
            if (ins_ok)
            begin
                slot_valid_reg[best_idx] <= 1'b1;
            end
            if (rem_ok)
            begin
                slot_valid_reg[best_idx] <= 1'b0;
                total_reg                <= add_total;
                if (src_ok)
                begin
                    per_src_reg[sidx] <= add_src;
                end
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (resolve)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (resolve)
        begin
            if (found)
            begin
                res_status_reg <= psb_pkg::STATUS_OK;
            end
            else if (is_remove)
            begin
                res_status_reg <= psb_pkg::STATUS_EMPTY;
            end
            else
            begin
                res_status_reg <= psb_pkg::STATUS_FULL;
            end
            res_value_reg <= rem_ok ? best.value : '0;
            res_prio_reg  <= rem_ok ? best.prio : '0;
            res_src_reg   <= rem_ok ? best.src : '0;
            res_occ_reg   <= 5'(count_next);
            res_total_reg <= rem_ok ? add_total : total_reg;
            res_ssum_reg  <= (rem_ok && src_ok) ? add_src : '0;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.status       = res_status_reg;
    assign result.out_value    = res_value_reg;
    assign result.out_priority = res_prio_reg;
    assign result.out_source   = res_src_reg;
    assign result.occupancy    = res_occ_reg;
    assign result.total_sum    = res_total_reg;
    assign result.source_sum   = res_ssum_reg;

    // checks
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == int'(count_reg))
        else $error("entry count out of step with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= SLOTS)
        else $error("entry count above slot total");

    a_remove_hits_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (resolve && rem_ok) |-> slot_valid_reg[best_idx])
        else $error("remove selected a free slot");

    a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == psb_pkg::ST_RESOLVE))
        else $error("result raised outside resolve");

endmodule

`default_nettype wire

// ===== dv/psb_result_checker.sv =====
// Watches the request and result channels of the priority slot buffer, keeps
// its own copy of the slot array and sums, and checks every result in order.
module psb_result_checker
    import psb_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int SOURCES = 3
) (
    input  wire logic clk,
    input  wire logic rst_n,
    psb_req_if        req_ch,
    psb_res_if        res_ch,
    output int        fail_count,
    output int        pending,
    output int        inserts_stored,
    output int        full_refusals,
    output int        removals,
    output int        empty_refusals,
    output int        peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    // one expected result, laid out as the result channel carries it
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [2:0]  prio;
        logic [1:0]  src;
        logic [4:0]  occupancy;
        logic [31:0] total;
        logic [31:0] src_sum;
    } cmd_outcome_t;

    entry_t       slot_store [SLOTS];
    bit           slot_used [SLOTS];
    logic [4:0]   fill_level;
    logic [31:0]  removed_total;
    logic [31:0]  source_totals [SOURCES];
    cmd_outcome_t awaited_results [$];

    // apply one request to the shadow buffer and work out its result
    function automatic cmd_outcome_t serve_command(input logic op, input logic [31:0] new_val,
                                                   input logic [2:0] new_prio,
                                                   input logic [1:0] new_src);
        cmd_outcome_t res;
        int           pick;
        res  = '0;
        pick = -1;
        if (op == CMD_INSERT)
        begin
            // lowest free slot
            for (int i = 0; i < SLOTS; i++)
                if (!slot_used[i] && pick < 0)
                    pick = i;
            if (pick < 0)
            begin
                res.status = STATUS_FULL;
                full_refusals++;
            end
            else
            begin
                slot_store[pick] = '{value: new_val, prio: new_prio, src: new_src};
                slot_used[pick]  = 1'b1;
                fill_level++;
                inserts_stored++;
            end
        end
        else
        begin
            // smallest priority number, lowest slot on a tie
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && (pick < 0 || slot_store[i].prio < slot_store[pick].prio))
                    pick = i;
            if (pick < 0)
            begin
                res.status = STATUS_EMPTY;
                empty_refusals++;
            end
            else
            begin
                res.value       = slot_store[pick].value;
                res.prio        = slot_store[pick].prio;
                res.src         = slot_store[pick].src;
                slot_used[pick] = 1'b0;
                fill_level--;
                removed_total += slot_store[pick].value;
                // tags beyond the source count only feed the running total
                if (int'(slot_store[pick].src) < SOURCES)
                begin
                    source_totals[slot_store[pick].src] += slot_store[pick].value;
                    res.src_sum = source_totals[slot_store[pick].src];
                end
                removals++;
            end
        end
        res.occupancy = fill_level;
        res.total     = removed_total;
        if (int'(fill_level) > peak_fill)
            peak_fill = int'(fill_level);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // results are compared before the request of the same edge is queued
    always @(posedge clk or negedge rst_n)
    begin : watch
        cmd_outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            for (int i = 0; i < SOURCES; i++)
                source_totals[i] = '0;
            fill_level     = '0;
            removed_total  = '0;
            awaited_results.delete();
            fail_count     = 0;
            pending        = 0;
            inserts_stored = 0;
            full_refusals  = 0;
            removals       = 0;
            empty_refusals = 0;
            peak_fill      = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, status %0d value %0h",
                             $time, res_ch.status, res_ch.out_value);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 32'(want.status), 32'(res_ch.status));
                    check_field("out_value", want.value, res_ch.out_value);
                    check_field("out_priority", 32'(want.prio), 32'(res_ch.out_priority));
                    check_field("out_source", 32'(want.src), 32'(res_ch.out_source));
                    check_field("occupancy", 32'(want.occupancy), 32'(res_ch.occupancy));
                    check_field("total_sum", want.total, res_ch.total_sum);
                    check_field("source_sum", want.src_sum, res_ch.source_sum);
                end
            end
            if (req_ch.valid && req_ch.ready)
                awaited_results.push_back(serve_command(req_ch.cmd, req_ch.value,
                                                        req_ch.priority_req, req_ch.source));
            pending = awaited_results.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psb_pkg::*;

    localparam int SLOTS        = 16;
    localparam int SOURCES      = 3;
    localparam int DIRECTED     = 22;
    localparam int RANDOM_ITEMS = 1000;
    localparam int STEADY_FROM  = DIRECTED + 850;
    localparam int HOLD_AT      = DIRECTED + 300;
    localparam int DRAIN_AT     = DIRECTED + 600;
    localparam int LONG_HOLD    = 400;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;
    localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psb_req_if request_ch ();
    psb_res_if result_ch ();

    int fail_count;
    int pending;
    int inserts_stored;
    int full_refusals;
    int removals;
    int empty_refusals;
    int peak_fill;

    int issued      = 0;
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit hold_armed  = 1'b0;
    bit hold_taken  = 1'b0;

    priority_slot_buffer_top #(
        .SLOTS   (SLOTS),
        .SOURCES (SOURCES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    psb_result_checker #(
        .SLOTS   (SLOTS),
        .SOURCES (SOURCES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_ch         (request_ch),
        .res_ch         (result_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .inserts_stored (inserts_stored),
        .full_refusals  (full_refusals),
        .removals       (removals),
        .empty_refusals (empty_refusals),
        .peak_fill      (peak_fill)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("%0t: run timed out with %0d results outstanding", $time, pending);
        $display("FAIL");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off
    initial
    begin : result_pacing
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // data values leaning on the extremes so the sums wrap often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return MAX_POS;
            1: return MAX_NEG;
            2: return ALL_ONE;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // offer one request, hold it until taken, then maybe idle a while
    task automatic issue(input logic op, input logic [31:0] val, input logic [2:0] prio,
                         input logic [1:0] src);
        int gap;
        request_ch.valid        <= 1'b1;
        request_ch.cmd          <= op;
        request_ch.value        <= val;
        request_ch.priority_req <= prio;
        request_ch.source       <= src;
        do
            @(posedge clk);
        while (!request_ch.ready);
        issued++;
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            request_ch.valid <= 1'b0;
            request_ch.value <= $urandom;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        request_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int  chunk_len;
        int  insert_pct;
        bit  tie_heavy;
        bit  drained_once;
        drained_once            = 1'b0;
        request_ch.valid        = 1'b0;
        request_ch.cmd          = CMD_INSERT;
        request_ch.value        = '0;
        request_ch.priority_req = '0;
        request_ch.source       = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // remove on an empty buffer, with junk in the unused fields
        issue(CMD_REMOVE, 32'h5A5A_5A5A, 3'd5, 2'd3);
        // extremes, a priority-0 tie and a tag beyond the source count
        issue(CMD_INSERT, MAX_POS, 3'd7, 2'd0);
        issue(CMD_INSERT, MAX_NEG, 3'd0, 2'd1);
        issue(CMD_INSERT, ALL_ONE, 3'd3, 2'd2);
        issue(CMD_INSERT, 32'd5, 3'd3, 2'd3);
        issue(CMD_INSERT, 32'd123, 3'd0, 2'd2);
        // tie: lower slot goes first
        issue(CMD_REMOVE, '0, 3'd0, 2'd0);
        issue(CMD_REMOVE, ALL_ONE, 3'd7, 2'd3);
        // fill to capacity with large values, the last insert is refused
        for (int i = 0; i < 14; i++)
            issue(CMD_INSERT, MAX_POS - i, i[2:0], i[1:0]);

        // random phases: fill-heavy, balanced and drain-heavy
        while (issued < DIRECTED + RANDOM_ITEMS)
        begin
            chunk_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 50;
                default: insert_pct = 20;
            endcase
            tie_heavy  = ($urandom_range(0, 3) == 0);
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (chunk_len)
            begin
                if (issued >= STEADY_FROM)
                begin
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                if (issued >= HOLD_AT)
                    hold_armed = 1'b1;
                if (!drained_once && issued >= DRAIN_AT)
                begin
                    drain();
                    drained_once = 1'b1;
                end
                if ($urandom_range(1, 100) <= insert_pct)
                    issue(CMD_INSERT, pick_value(),
                          tie_heavy ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)));
                else
                    issue(CMD_REMOVE, $urandom, 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)));
            end
        end

        // wind down
        drain();
        repeat (2 * SLOTS + 8) @(posedge clk);

        $display("Covered %0d requests: %0d stored, %0d full, %0d removed, %0d empty",
                 issued, inserts_stored, full_refusals, removals, empty_refusals);
        $display("Peak occupancy %0d of %0d slots, with a long result hold-off and a full drain",
                 peak_fill, SLOTS);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
